[src/shs_pkg.sv]
package shs_pkg;

   // Default depth of the queue between the front and the back.
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   typedef logic [31:0] word_type;

   // One queued input beat, after idle beats have been dropped.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       finish;
   } item_type;

   // Standard initial chaining value; index 0 is H0.
   localparam logic [4:0][31:0] CHAIN_IV = {
      32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
   };

   localparam word_type ROUND_K0 = 32'h5a827999;
   localparam word_type ROUND_K1 = 32'h6ed9eba1;
   localparam word_type ROUND_K2 = 32'h8f1bbcdc;
   localparam word_type ROUND_K3 = 32'hca62c1d6;

   localparam logic [7:0] PAD_MARK_BYTE   = 8'h80;
   localparam logic [5:0] BLOCK_LAST_BYTE = 6'd63;
   localparam logic [5:0] LEN_FIRST_BYTE  = 6'd56;
   localparam logic [6:0] ROUND_LAST      = 7'd79;
   localparam logic [2:0] LEN_LAST_BYTE   = 3'd7;
   localparam logic [2:0] DIGEST_LAST     = 3'd4;
   localparam logic [63:0] BITS_PER_BYTE  = 64'd8;

   // Mixing function of one round, chosen by the round number.
   function automatic word_type round_mix(input logic [6:0] rnd, input word_type b,
                                          input word_type c, input word_type d);
      word_type f;
      priority if (rnd < 7'd20) begin
         f = (b & c) | (~b & d);
      end else if (rnd < 7'd40) begin
         f = b ^ c ^ d;
      end else if (rnd < 7'd60) begin
         f = (b & c) | (b & d) | (c & d);
      end else begin
         f = b ^ c ^ d;
      end
      return f;
   endfunction

   // Additive constant of one round.
   function automatic word_type round_const(input logic [6:0] rnd);
      word_type k;
      priority if (rnd < 7'd20) begin
         k = ROUND_K0;
      end else if (rnd < 7'd40) begin
         k = ROUND_K1;
      end else if (rnd < 7'd60) begin
         k = ROUND_K2;
      end else begin
         k = ROUND_K3;
      end
      return k;
   endfunction

endpackage

[src/shs_front.sv]
module shs_front #(
   parameter int DEPTH = shs_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,
   input  logic              req_tuser,
   input  logic              req_tlast,
   output logic              q_valid,
   output shs_pkg::item_type q_item,
   input  logic              q_pop
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
   localparam logic [CW-1:0] COUNT_FULL = CW'(DEPTH);

   shs_pkg::item_type    slot_ff [DEPTH];
   logic [PW-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]        count_ff, count_in;
   logic                 take;
   logic                 keep;
   logic                 pop;

   // A beat with neither a byte nor a finish changes nothing, so it is dropped here.
   assign req_tready = (count_ff != COUNT_FULL);
   assign take       = req_tvalid && req_tready;
   assign keep       = take && (req_tuser || req_tlast);
   assign q_valid    = (count_ff != '0);
   assign q_item     = slot_ff[rd_ptr_ff];
   assign pop        = q_pop && q_valid;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (keep) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (keep && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !keep) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage needs no reset.
   always_ff @(posedge clock) begin
      if (keep) begin
         slot_ff[wr_ptr_ff] <= '{data_byte: req_tdata, has_byte: req_tuser,
                                 finish: req_tlast};
      end
   end

endmodule

[src/shs_core.sv]
module shs_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  shs_pkg::item_type q_item,
   output logic              q_pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [31:0]       rsp_tdata,
   output logic [2:0]        rsp_tuser,
   output logic              rsp_tlast
);

   typedef enum logic [4:0] {
      ST_TAKE  = 5'b00001,
      ST_PAD   = 5'b00010,
      ST_ROUND = 5'b00100,
      ST_ADD   = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   typedef enum logic [2:0] {
      PAD_MARK = 3'b001,
      PAD_ZERO = 3'b010,
      PAD_LEN  = 3'b100
   } pad_type;

   state_type         state_ff, state_in;
   pad_type           pad_ff, pad_in;
   logic [5:0]        fill_ff, fill_in;
   logic [23:0]       acc_ff, acc_in;
   shs_pkg::word_type sched_ff [16];
   shs_pkg::word_type sched_in [16];
   shs_pkg::word_type chain_ff [5];
   shs_pkg::word_type chain_in [5];
   shs_pkg::word_type a_ff, b_ff, c_ff, d_ff, e_ff;
   shs_pkg::word_type a_in, b_in, c_in, d_in, e_in;
   logic [6:0]        rnd_ff, rnd_in;
   logic [63:0]       total_ff, total_in;
   logic [63:0]       len_ff, len_in;
   logic [2:0]        len_cnt_ff, len_cnt_in;
   logic              fin_pend_ff, fin_pend_in;
   logic              done_ff, done_in;
   logic [2:0]        out_idx_ff, out_idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   shs_pkg::word_type rsp_data_ff, rsp_data_in;
   logic [2:0]        rsp_idx_ff, rsp_idx_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              push_en;
   logic [7:0]        push_byte;
   logic              block_full;
   logic              len_phase;
   logic              out_load;
   logic [63:0]       total_next;
   shs_pkg::word_type w_new;
   shs_pkg::word_type temp;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_idx_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign q_pop      = (state_ff == ST_TAKE) && q_valid;
   assign total_next = total_ff + (q_item.has_byte ? shs_pkg::BITS_PER_BYTE : 64'd0);
   assign len_phase  = (pad_ff == PAD_LEN) ||
                       ((pad_ff == PAD_ZERO) && (fill_ff == shs_pkg::LEN_FIRST_BYTE));
   assign out_load   = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_tready);

   // Byte source: a message byte from the queue or a generated padding byte.
   always_comb begin
      push_en   = 1'b0;
      push_byte = q_item.data_byte;
      if (state_ff == ST_TAKE) begin
         push_en = q_valid && q_item.has_byte;
      end else if (state_ff == ST_PAD) begin
         push_en = 1'b1;
         if (pad_ff == PAD_MARK) begin
            push_byte = shs_pkg::PAD_MARK_BYTE;
         end else if (len_phase) begin
            push_byte = len_ff[63:56];
         end else begin
            push_byte = 8'h00;
         end
      end
   end

   assign block_full = push_en && (fill_ff == shs_pkg::BLOCK_LAST_BYTE);

   // Message schedule word for sixteen rounds ahead, and the round sum.
   assign w_new = {sched_ff[13][30:0] ^ sched_ff[8][30:0] ^ sched_ff[2][30:0] ^
                   sched_ff[0][30:0],
                   sched_ff[13][31] ^ sched_ff[8][31] ^ sched_ff[2][31] ^ sched_ff[0][31]};
   assign temp  = {a_ff[26:0], a_ff[31:27]} + shs_pkg::round_mix(rnd_ff, b_ff, c_ff, d_ff)
                  + e_ff + shs_pkg::round_const(rnd_ff) + sched_ff[0];

   // Next-state logic of the sequencer.
   always_comb begin
      state_in     = state_ff;
      pad_in       = pad_ff;
      fill_in      = fill_ff;
      acc_in       = acc_ff;
      sched_in     = sched_ff;
      chain_in     = chain_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      d_in         = d_ff;
      e_in         = e_ff;
      rnd_in       = rnd_ff;
      total_in     = total_ff;
      len_in       = len_ff;
      len_cnt_in   = len_cnt_ff;
      fin_pend_in  = fin_pend_ff;
      done_in      = done_ff;
      out_idx_in   = out_idx_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      // Pack a byte big-endian; each fourth byte completes a word.
      if (push_en) begin
         acc_in  = {acc_ff[15:0], push_byte};
         fill_in = fill_ff + 1'b1;
         if (fill_ff[1:0] == 2'b11) begin
            for (int i = 0; i < 15; i++) begin
               sched_in[i] = sched_ff[i + 1];
            end
            sched_in[15] = {acc_ff, push_byte};
         end
      end

      unique case (state_ff)
         ST_TAKE: begin
            if (q_valid) begin
               total_in = total_next;
               if (q_item.finish) begin
                  fin_pend_in = 1'b1;
                  pad_in      = PAD_MARK;
                  len_in      = total_next;
                  len_cnt_in  = '0;
                  state_in    = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            if (pad_ff == PAD_MARK) begin
               pad_in = PAD_ZERO;
            end else if (len_phase) begin
               pad_in     = PAD_LEN;
               len_in     = {len_ff[55:0], 8'h00};
               len_cnt_in = len_cnt_ff + 1'b1;
               if (len_cnt_ff == shs_pkg::LEN_LAST_BYTE) begin
                  done_in     = 1'b1;
                  fin_pend_in = 1'b0;
               end
            end
         end
         ST_ROUND: begin
            a_in   = temp;
            b_in   = a_ff;
            c_in   = {b_ff[1:0], b_ff[31:2]};
            d_in   = c_ff;
            e_in   = d_ff;
            rnd_in = rnd_ff + 1'b1;
            for (int i = 0; i < 15; i++) begin
               sched_in[i] = sched_ff[i + 1];
            end
            sched_in[15] = w_new;
            if (rnd_ff == shs_pkg::ROUND_LAST) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            chain_in[0] = chain_ff[0] + a_ff;
            chain_in[1] = chain_ff[1] + b_ff;
            chain_in[2] = chain_ff[2] + c_ff;
            chain_in[3] = chain_ff[3] + d_ff;
            chain_in[4] = chain_ff[4] + e_ff;
            priority if (done_ff) begin
               state_in = ST_EMIT;
            end else if (fin_pend_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_TAKE;
            end
         end
         ST_EMIT: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = chain_ff[out_idx_ff];
               rsp_idx_in   = out_idx_ff;
               rsp_last_in  = (out_idx_ff == shs_pkg::DIGEST_LAST);
               out_idx_in   = out_idx_ff + 1'b1;
               if (out_idx_ff == shs_pkg::DIGEST_LAST) begin
                  // Digest handed over: start the next message.
                  for (int i = 0; i < 5; i++) begin
                     chain_in[i] = shs_pkg::CHAIN_IV[i];
                  end
                  total_in   = '0;
                  out_idx_in = '0;
                  done_in    = 1'b0;
                  state_in   = ST_TAKE;
               end
            end
         end
         default: begin
            state_in = ST_TAKE;
         end
      endcase

      // A full block starts the compression from the current chaining value.
      if (block_full) begin
         state_in = ST_ROUND;
         rnd_in   = '0;
         a_in     = chain_ff[0];
         b_in     = chain_ff[1];
         c_in     = chain_ff[2];
         d_in     = chain_ff[3];
         e_in     = chain_ff[4];
      end
   end

   // Control state and the chaining value, both initialised by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_TAKE;
         pad_ff       <= PAD_MARK;
         fill_ff      <= '0;
         rnd_ff       <= '0;
         total_ff     <= '0;
         len_cnt_ff   <= '0;
         fin_pend_ff  <= 1'b0;
         done_ff      <= 1'b0;
         out_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 5; i++) begin
            chain_ff[i] <= shs_pkg::CHAIN_IV[i];
         end
      end else begin
         state_ff     <= state_in;
         pad_ff       <= pad_in;
         fill_ff      <= fill_in;
         rnd_ff       <= rnd_in;
         total_ff     <= total_in;
         len_cnt_ff   <= len_cnt_in;
         fin_pend_ff  <= fin_pend_in;
         done_ff      <= done_in;
         out_idx_ff   <= out_idx_in;
         rsp_valid_ff <= rsp_valid_in;
         chain_ff     <= chain_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      sched_ff    <= sched_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      c_ff        <= c_in;
      d_ff        <= d_in;
      e_ff        <= e_in;
      len_ff      <= len_in;
      rsp_data_ff <= rsp_data_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

[src/sha1_stream_hasher.sv]
// SHA-1 hasher. Each req beat carries at most one message byte (tuser high) and may close
// the message (tlast high); a beat with neither is taken and ignored. Closing a message
// pads it and returns the digest as five rsp beats, H0 first, with tuser giving the word
// position and tlast marking H4; the next message then starts from the standard initial
// value. Accepted beats wait in a small queue while the back end works. The back end takes
// one byte per cycle, but none while it pads, compresses a block or emits a digest; every
// completed 64-byte block is compressed in 80 rounds of the single round unit and then
// added into the chaining value. A finish adds up to 72 padding bytes and one or two block
// compressions before the first digest word appears; the following message may enter
// while the last digest word waits in the output register.
module sha1_stream_hasher #(
   parameter int QUEUE_DEPTH = shs_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] has_byte
   input  logic        req_tlast,   // finish
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] digest_word
   output logic [2:0]  rsp_tuser,   // [2:0] word_index
   output logic        rsp_tlast    // last_word
);

   logic              q_valid;
   logic              q_pop;
   shs_pkg::item_type q_item;

   shs_front #(
      .DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   shs_core u_core (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[src/shs_checker.sv]
module shs_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [2:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // No result is shown right after reset.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // A stalled result beat holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled rsp beat changed");

   // The last flag sits on word four and nowhere else.
   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser == 3'd4)) && (rsp_tuser <= 3'd4))
      else $error("digest word position and last flag disagree");

   // Digest words follow each other without a gap once the first is taken.
   a_word_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         rsp_tvalid && (rsp_tuser == $past(rsp_tuser) + 3'd1))
      else $error("digest word sequence broken");

endmodule

bind sha1_stream_hasher shs_checker u_shs_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

[verif/sha1_stream_hasher_test.sv]
module sha1_stream_hasher_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int TOTAL_ITEMS   = 210;
   localparam int DRAIN_CYCLES  = 300;
   localparam int DIRECTED_SIZE = 10;

   // Well-known digests of the empty message and of "abc".
   localparam logic [159:0] EMPTY_DIGEST =
      160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709;
   localparam logic [159:0] ABC_DIGEST =
      160'ha9993e36_4706816a_ba3e2571_7850c26c_9cd0d89d;

   // Message lengths that sit on either side of the padding and block boundaries.
   localparam int EDGE_LENGTHS [9] = '{55, 56, 57, 63, 64, 65, 119, 120, 128};

   typedef struct packed {
      shs_pkg::word_type word;
      logic [2:0]        index;
      logic              last;
   } digest_beat_type;

   typedef struct packed {
      logic [7:0]   data;
      logic         has;
      logic         fin;
      logic         typed;
      logic [159:0] digest;
   } stim_row_type;

   // Directed beats; a digest is typed in only where it is a well-known value.
   localparam stim_row_type DIRECTED_ROWS [DIRECTED_SIZE] = '{
      '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
      '{8'h61, 1'b1, 1'b0, 1'b0, 160'h0},
      '{8'h62, 1'b1, 1'b0, 1'b0, 160'h0},
      '{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},
      '{8'hff, 1'b0, 1'b0, 1'b0, 160'h0},
      '{8'hff, 1'b1, 1'b0, 1'b0, 160'h0},
      '{8'h00, 1'b1, 1'b0, 1'b0, 160'h0},
      '{8'h80, 1'b1, 1'b1, 1'b0, 160'h0},
      '{8'h5a, 1'b0, 1'b0, 1'b0, 160'h0},
      '{8'ha5, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST}
   };

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] data_byte
   logic        req_tuser;   // [0] has_byte
   logic        req_tlast;   // finish
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // [31:0] digest_word
   logic [2:0]  rsp_tuser;   // [2:0] word_index
   logic        rsp_tlast;   // last_word

   // Running hash state of the checker.
   shs_pkg::word_type hash_chain [5];
   shs_pkg::word_type hash_block [16];
   logic [63:0]       hash_bits;
   logic [5:0]        hash_fill;

   digest_beat_type pending_words [$];
   int              mismatch_count = 0;
   int              cycle_count = 0;

   sha1_stream_hasher dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Free-running clock.
   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Start a new message from the standard initial value.
   function automatic void hash_restart();
      for (int i = 0; i < 5; i++) begin
         hash_chain[i] = shs_pkg::CHAIN_IV[i];
      end
      hash_bits = 64'd0;
      hash_fill = 6'd0;
   endfunction

   // Eighty rounds over the full block, folded into the chaining value.
   function automatic void hash_compress();
      shs_pkg::word_type sched [80];
      shs_pkg::word_type a, b, c, d, e, f, k, t, x;
      for (int i = 0; i < 16; i++) begin
         sched[i] = hash_block[i];
      end
      for (int i = 16; i < 80; i++) begin
         x = sched[i-3] ^ sched[i-8] ^ sched[i-14] ^ sched[i-16];
         sched[i] = {x[30:0], x[31]};
      end
      a = hash_chain[0];
      b = hash_chain[1];
      c = hash_chain[2];
      d = hash_chain[3];
      e = hash_chain[4];
      for (int i = 0; i < 80; i++) begin
         if (i < 20) begin
            f = (b & c) | (~b & d);
            k = shs_pkg::ROUND_K0;
         end else if (i < 40) begin
            f = b ^ c ^ d;
            k = shs_pkg::ROUND_K1;
         end else if (i < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = shs_pkg::ROUND_K2;
         end else begin
            f = b ^ c ^ d;
            k = shs_pkg::ROUND_K3;
         end
         t = {a[26:0], a[31:27]} + f + e + k + sched[i];
         e = d;
         d = c;
         c = {b[1:0], b[31:2]};
         b = a;
         a = t;
      end
      hash_chain[0] += a;
      hash_chain[1] += b;
      hash_chain[2] += c;
      hash_chain[3] += d;
      hash_chain[4] += e;
   endfunction

   // Bytes fill each word from the most significant end.
   function automatic void hash_push_byte(input logic [7:0] value);
      hash_block[hash_fill[5:2]][(3 - hash_fill[1:0]) * 8 +: 8] = value;
      hash_fill = hash_fill + 6'd1;
      if (hash_fill == 6'd0) begin
         hash_compress();
      end
   endfunction

   // Applies one accepted beat; returns 1 with the digest when the message closes.
   function automatic bit hash_take_item(input logic [7:0] data, input logic has,
                                         input logic fin, output logic [159:0] digest);
      logic [63:0] length_bits;
      digest = '0;
      if (has) begin
         hash_push_byte(data);
         hash_bits = hash_bits + 64'd8;
      end
      if (!fin) begin
         return 1'b0;
      end
      length_bits = hash_bits;
      hash_push_byte(shs_pkg::PAD_MARK_BYTE);
      while (hash_fill != shs_pkg::LEN_FIRST_BYTE) begin
         hash_push_byte(8'h00);
      end
      for (int i = 0; i < 8; i++) begin
         hash_push_byte(length_bits[8 * (7 - i) +: 8]);
      end
      digest = {hash_chain[0], hash_chain[1], hash_chain[2], hash_chain[3], hash_chain[4]};
      hash_restart();
      return 1'b1;
   endfunction

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   // Drives one req beat at the falling edge and waits for it to be taken.
   task automatic send_req_beat(input logic [7:0] data, input logic has, input logic fin,
                                input bit burst, input bit typed,
                                input logic [159:0] typed_digest);
      int              gap;
      logic [159:0]    digest;
      digest_beat_type beat;
      gap = burst ? 0 : pick_gap();
      repeat (gap) @(negedge clock) req_tvalid <= 1'b0;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= has;
      req_tlast  <= fin;
      do @(posedge clock); while (!req_tready);
      if (hash_take_item(data, has, fin, digest)) begin
         if (typed) begin
            digest = typed_digest;
         end
         for (int i = 0; i <= shs_pkg::DIGEST_LAST; i++) begin
            beat.word  = digest[159 - 32 * i -: 32];
            beat.index = i[2:0];
            beat.last  = (i == shs_pkg::DIGEST_LAST);
            pending_words.push_back(beat);
         end
      end
   endtask

   // Receiver stalls: random stall lengths between runs of readiness, some of them long.
   initial begin
      int stall;
      int run;
      rsp_tready = 1'b0;
      forever begin
         stall = pick_gap();
         run   = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 6);
         repeat (stall) @(negedge clock) rsp_tready <= 1'b0;
         repeat (run) @(negedge clock) rsp_tready <= 1'b1;
      end
   end

   // Every accepted rsp beat is compared with the oldest digest word due.
   always @(posedge clock) begin : rsp_check
      digest_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_words.size() == 0) begin
            $display("%0t: unexpected digest beat: word %h index %0d last %0b",
                     $time, rsp_tdata, rsp_tuser, rsp_tlast);
            mismatch_count++;
         end else begin
            want = pending_words.pop_front();
            if (want.word !== rsp_tdata || want.index !== rsp_tuser
                || want.last !== rsp_tlast) begin
               $display("%0t: digest mismatch: expected word %h index %0d last %0b,",
                        $time, want.word, want.index, want.last);
               $display("   actual word %h index %0d last %0b",
                        rsp_tdata, rsp_tuser, rsp_tlast);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Main sequence: reset, directed table, random messages, drain.
   initial begin
      int           items_sent;
      int           msg_count;
      int           msg_len;
      int           r;
      bit           split;
      bit           burst;
      stim_row_type row;
      items_sent = 0;
      msg_count  = 0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      req_tuser  = 1'b0;
      req_tlast  = 1'b0;
      hash_restart();
      repeat (10) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Directed beats, including the empty message and "abc".
      for (int i = 0; i < DIRECTED_SIZE; i++) begin
         row = DIRECTED_ROWS[i];
         send_req_beat(row.data, row.has, row.fin, 1'b0, row.typed, row.digest);
         items_sent++;
      end

      // Random messages, mostly short, some on the padding edges, a few long.
      while (items_sent < TOTAL_ITEMS) begin
         burst = ($urandom_range(0, 3) == 0);
         split = $urandom_range(0, 1);
         // Hold off now and then until every digest word has come back.
         if (msg_count == 1 || $urandom_range(0, 9) == 0) begin
            @(negedge clock) req_tvalid <= 1'b0;
            while (pending_words.size() != 0) @(posedge clock);
         end
         r = $urandom_range(0, 99);
         if (r < 65) begin
            msg_len = $urandom_range(0, 12);
         end else if (r < 88) begin
            msg_len = EDGE_LENGTHS[$urandom_range(0, 8)];
         end else begin
            msg_len = $urandom_range(13, 80);
         end
         for (int i = 0; i < msg_len; i++) begin
            if ($urandom_range(0, 9) == 0) begin
               send_req_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0, burst, 1'b0, '0);
               items_sent++;
            end
            send_req_beat(8'($urandom_range(0, 255)), 1'b1, (i == msg_len - 1) && !split,
                          burst, 1'b0, '0);
            items_sent++;
         end
         // Finish on a beat of its own, with a byte value that must be ignored.
         if (msg_len == 0 || split) begin
            send_req_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1, burst, 1'b0, '0);
            items_sent++;
         end
         msg_count++;
      end
      @(negedge clock) req_tvalid <= 1'b0;

      while (pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
